### rtl/core/bhcs_pkg.sv
// Package for the box HSV coverage selector: shared constants, widths and types.
// Used by every module in rtl/core.
package bhcs_pkg;

   localparam int unsigned SampleStep = 10;
   localparam int unsigned MaxBoxes   = 64;
   localparam int unsigned PhaseW     = 4;
   localparam int unsigned BoxW       = 6;
   localparam int unsigned BoxCntW    = (MaxBoxes > 1) ? $clog2(MaxBoxes) : 1;
   localparam int unsigned QueueDepth = 4;
   localparam int unsigned QueueAw    = $clog2(QueueDepth);

   // Register indexes on the configuration port.
   localparam logic [2:0] RegMinHue = 3'd0;
   localparam logic [2:0] RegMaxHue = 3'd1;
   localparam logic [2:0] RegMinSat = 3'd2;
   localparam logic [2:0] RegMaxSat = 3'd3;
   localparam logic [2:0] RegMinVal = 3'd4;
   localparam logic [2:0] RegMaxVal = 3'd5;
   localparam logic [2:0] RegFrac   = 3'd6;

   // States of the front part: waiting for a pixel, dividing, handing off.
   typedef enum logic [1:0] {
      FrontIdle   = 2'd0,
      FrontDivide = 2'd1,
      FrontEmit   = 2'd2
   } front_state_type;

   typedef struct packed {
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic        row_end;
      logic        box_end;
      logic        set_end;
      logic [15:0] box_confidence;
   } req_word_type;

   typedef struct packed {
      logic [5:0]  box_number;
      logic [15:0] hits;
      logic [15:0] samples;
      logic        box_passes;
      logic        winner_valid;
      logic [5:0]  winner_number;
      logic [15:0] winner_confidence;
      logic        set_done;
   } rsp_word_type;

   typedef struct packed {
      logic [7:0]  min_hue;
      logic [7:0]  max_hue;
      logic [7:0]  min_sat;
      logic [7:0]  max_sat;
      logic [7:0]  min_val;
      logic [7:0]  max_val;
      logic [15:0] pass_fraction;
   } cfg_type;

   // What the front part hands the back part for one sampled pixel or box end.
   typedef struct packed {
      logic        sampled;
      logic        hit;
      logic        box_end;
      logic        set_end;
      logic [15:0] confidence;
   } event_type;

endpackage

### rtl/core/bhcs_stream_if.sv
// Valid/ready stream interface carrying one word of a given payload type.
// The payload type is a parameter; this interface does not depend on bhcs_pkg.
interface bhcs_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/bhcs_front.sv
// Front part: sampling phases and multi-cycle RGB-to-HSV test of each sampled pixel.
// Depends on bhcs_pkg. Emits one event word per pixel that is sampled or ends a box.
module bhcs_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  bhcs_pkg::req_word_type in_data,
   output logic                   in_ready,
   input  bhcs_pkg::cfg_type      cfg,
   output logic                   ev_valid,
   output bhcs_pkg::event_type    ev_data,
   input  logic                   ev_space
);
   // A sampled pixel is loaded in its accept cycle, then hue and saturation are
   // divided together by eight shift-and-subtract steps, then the event is handed
   // to the queue. Pixels that are neither sampled nor a box end are taken in idle.
   bhcs_pkg::front_state_type state_ff, state_in;
   logic [bhcs_pkg::PhaseW-1:0] col_ff, col_in, row_ff, row_in;
   logic [2:0]  step_ff;
   logic        take, sampled;
   logic [7:0]  r, g, b, mx, mn, diff;
   logic signed [9:0] dl;
   logic [7:0]  off;
   logic signed [17:0] n;
   logic [17:0] hnum;   // 2*num + diff, num < 180*diff
   logic [16:0] snum;   // 2*255*diff + v
   logic [17:0] hrem_ff, hdiv_ff;
   logic [16:0] srem_ff, sdiv_ff;
   logic [7:0]  hq_ff, sq_ff, v_ff, diff_ff;
   logic        smp_ff, be_ff, se_ff;
   logic [15:0] cf_ff;
   logic [7:0]  hue, sat;
   logic        hit;

   assign sampled = (col_ff == '0) && (row_ff == '0);
   assign take = in_valid && in_ready;

   always_comb begin
      state_in = state_ff;
      in_ready = 1'b0;
      ev_valid = 1'b0;
      unique case (state_ff)
         bhcs_pkg::FrontIdle: begin
            in_ready = 1'b1;
            if (in_valid && sampled) state_in = bhcs_pkg::FrontDivide;
            else if (in_valid && in_data.box_end) state_in = bhcs_pkg::FrontEmit;
         end
         bhcs_pkg::FrontDivide: begin
            if (step_ff == 3'd7) state_in = bhcs_pkg::FrontEmit;
         end
         bhcs_pkg::FrontEmit: begin
            ev_valid = 1'b1;
            if (ev_space) state_in = bhcs_pkg::FrontIdle;
         end
         default: state_in = bhcs_pkg::FrontIdle;
      endcase
   end

   always_comb begin
      r = in_data.red; g = in_data.green; b = in_data.blue;
      mx = r; mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      diff = mx - mn;
      if (mx == r) begin
         dl = 10'(signed'({2'b0, g})) - 10'(signed'({2'b0, b})); off = 8'd0;
      end else if (mx == g) begin
         dl = 10'(signed'({2'b0, b})) - 10'(signed'({2'b0, r})); off = 8'd60;
      end else begin
         dl = 10'(signed'({2'b0, r})) - 10'(signed'({2'b0, g})); off = 8'd120;
      end
      n = signed'(18'(off) * 18'(diff)) + 18'sd30 * 18'(dl);
      if (n < 0) n = n + 18'sd180 * signed'(18'(diff));
      hnum = {n[16:0], 1'b0} + {10'd0, diff};
      snum = 17'd510 * {9'd0, diff} + {9'd0, mx};
      col_in = col_ff; row_in = row_ff;
      if (take) begin
         col_in = (32'(col_ff) + 1 >= bhcs_pkg::SampleStep) ? '0 : col_ff + 1'b1;
         if (in_data.row_end || in_data.box_end) begin
            col_in = '0;
            row_in = (32'(row_ff) + 1 >= bhcs_pkg::SampleStep) ? '0 : row_ff + 1'b1;
         end
         if (in_data.box_end) row_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bhcs_pkg::FrontIdle;
         col_ff <= '0; row_ff <= '0;
      end else begin
         state_ff <= state_in;
         col_ff <= col_in; row_ff <= row_in;
      end
   end

   // The divisors start at 2*diff and 2*v shifted up by seven places.
   always_ff @(posedge clock) begin
      if (take) begin
         smp_ff <= sampled; be_ff <= in_data.box_end; se_ff <= in_data.set_end;
         cf_ff <= in_data.box_confidence; v_ff <= mx; diff_ff <= diff;
         hrem_ff <= hnum; hdiv_ff <= {2'b0, diff, 8'd0};
         srem_ff <= snum; sdiv_ff <= {1'b0, mx, 8'd0};
         hq_ff <= '0; sq_ff <= '0; step_ff <= '0;
      end else if (state_ff == bhcs_pkg::FrontDivide) begin
         if (hrem_ff >= hdiv_ff) begin
            hrem_ff <= hrem_ff - hdiv_ff; hq_ff <= {hq_ff[6:0], 1'b1};
         end else begin
            hq_ff <= {hq_ff[6:0], 1'b0};
         end
         if (srem_ff >= sdiv_ff) begin
            srem_ff <= srem_ff - sdiv_ff; sq_ff <= {sq_ff[6:0], 1'b1};
         end else begin
            sq_ff <= {sq_ff[6:0], 1'b0};
         end
         hdiv_ff <= hdiv_ff >> 1;
         sdiv_ff <= sdiv_ff >> 1;
         step_ff <= step_ff + 1'b1;
      end
   end

   // A gray pixel has hue and saturation zero; a hue that rounds to 180 wraps to 0.
   always_comb begin
      hue = (diff_ff == '0) ? 8'd0 : hq_ff;
      if (hue >= 8'd180) hue = hue - 8'd180;
      sat = (v_ff == '0) ? 8'd0 : sq_ff;
      hit = hue >= cfg.min_hue && hue <= cfg.max_hue &&
            sat >= cfg.min_sat && sat <= cfg.max_sat &&
            v_ff >= cfg.min_val && v_ff <= cfg.max_val;
   end

   assign ev_data = '{sampled: smp_ff, hit: hit, box_end: be_ff,
                      set_end: se_ff, confidence: cf_ff};
endmodule

### rtl/core/bhcs_queue.sv
// Short FIFO of event words between the front and back parts.
// Depends on bhcs_pkg for depth and the event type.
module bhcs_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_en,
   input  bhcs_pkg::event_type wr_data,
   output logic                space,
   output logic                rd_valid,
   output bhcs_pkg::event_type rd_data,
   input  logic                rd_en
);
   bhcs_pkg::event_type mem_ff [bhcs_pkg::QueueDepth];
   logic [bhcs_pkg::QueueAw-1:0] wp_ff, rp_ff;
   logic [bhcs_pkg::QueueAw:0]   cnt_ff;
   logic rd, wr;

   // The front offers one word at a time and writes only when there is room.
   assign space = cnt_ff != (bhcs_pkg::QueueAw + 1)'(bhcs_pkg::QueueDepth);
   assign rd_valid = cnt_ff != '0;
   assign rd_data = mem_ff[rp_ff];
   assign rd = rd_en && rd_valid;
   assign wr = wr_en && space;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         if (wr) wp_ff <= wp_ff + 1'b1;
         if (rd) rp_ff <= rp_ff + 1'b1;
         unique case ({wr, rd})
            2'b10:   cnt_ff <= cnt_ff + 1'b1;
            2'b01:   cnt_ff <= cnt_ff - 1'b1;
            default: ;
         endcase
      end
   end
   always_ff @(posedge clock) begin
      if (wr) mem_ff[wp_ff] <= wr_data;
   end
endmodule

### rtl/core/bhcs_back.sv
// Back part: counts hits and samples, decides pass, tracks the winner.
// Depends on bhcs_pkg. Holds one result word in an output register.
module bhcs_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   ev_valid,
   input  bhcs_pkg::event_type    ev_data,
   output logic                   ev_take,
   input  logic [15:0]            pass_fraction,
   output logic                   out_valid,
   output bhcs_pkg::rsp_word_type out_data,
   input  logic                   out_ready
);
   logic [15:0] hit_ff, smp_ff, hit_in, smp_in;
   logic [bhcs_pkg::BoxCntW-1:0] box_ff, box_in;
   logic bv_ff; logic [5:0] bn_ff; logic [15:0] bc_ff;
   logic ov_ff; bhcs_pkg::rsp_word_type od_ff;
   logic [31:0] prod_ff;
   logic pend_ff; bhcs_pkg::event_type pev_ff;
   logic passes, win;

   // At a box end the product is registered when the event is taken and the compare is made while pend_ff is set.
   assign ev_take = !pend_ff && (!ov_ff || out_ready);
   assign out_valid = ov_ff;
   assign out_data = od_ff;

   always_comb begin
      hit_in = hit_ff; smp_in = smp_ff;
      if (ev_data.sampled) begin
         if (smp_ff != 16'hFFFF) smp_in = smp_ff + 1'b1;
         if (ev_data.hit && hit_ff != 16'hFFFF) hit_in = hit_ff + 1'b1;
      end
      passes = {hit_ff, 16'h0} >= prod_ff;
      win = passes && (!bv_ff || pev_ff.confidence > bc_ff);
      box_in = (32'(box_ff) + 1 >= bhcs_pkg::MaxBoxes) ? '0 : box_ff + 1'b1;
   end

   // The output register is always empty in the compare cycle, since a box end
   // is only taken when it is empty or the waiting result leaves in the same cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= '0; smp_ff <= '0; box_ff <= '0; bv_ff <= 1'b0;
         bn_ff <= '0; bc_ff <= '0; ov_ff <= 1'b0; pend_ff <= 1'b0;
      end else if (pend_ff) begin
         pend_ff <= 1'b0;
         ov_ff <= 1'b1;
         od_ff.box_number <= 6'(box_ff);
         od_ff.hits <= hit_ff; od_ff.samples <= smp_ff;
         od_ff.box_passes <= passes;
         od_ff.winner_valid <= bv_ff || win;
         od_ff.winner_number <= win ? 6'(box_ff) : bn_ff;
         od_ff.winner_confidence <= win ? pev_ff.confidence : bc_ff;
         od_ff.set_done <= pev_ff.set_end;
         hit_ff <= '0; smp_ff <= '0;
         if (pev_ff.set_end) begin
            box_ff <= '0; bv_ff <= 1'b0; bn_ff <= '0; bc_ff <= '0;
         end else begin
            box_ff <= box_in;
            if (win) begin
               bv_ff <= 1'b1; bn_ff <= 6'(box_ff); bc_ff <= pev_ff.confidence;
            end
         end
      end else begin
         if (ov_ff && out_ready) ov_ff <= 1'b0;
         if (ev_valid && ev_take) begin
            hit_ff <= hit_in; smp_ff <= smp_in;
            pend_ff <= ev_data.box_end;
         end
      end
   end
   always_ff @(posedge clock) begin
      if (ev_valid && ev_take) begin
         pev_ff <= ev_data;
         prod_ff <= pass_fraction * smp_in;
      end
   end
endmodule

### rtl/core/box_hsv_coverage_selector.sv
// Top level of the box HSV coverage selector: APB registers, front, queue, back.
// Depends on bhcs_pkg, bhcs_stream_if and the bhcs_front/queue/back modules.
//
// Pixels of each box arrive in raster order on req; every tenth row and column
// is sampled, converted to HSV and tested against the inclusive limits. A pixel
// that is neither sampled nor a box end is taken while the front part is idle.
// A sampled pixel holds req through its accept cycle, eight shift-and-subtract
// steps that divide hue and saturation together, and the hand-off of the event
// word to a four-word queue; an unsampled box end goes straight to the hand-off.
// The back part counts samples and hits and, at the word carrying box_end, forms
// hits*2^16 against pass_fraction*samples and updates the winner, then offers
// one result word on rsp. While a result waits on rsp the back part stops, the
// queue fills and then req stalls.
// Registers are written over APB at byte address 4*i and should be changed only
// while idle.
module box_hsv_coverage_selector (
   input  logic        clock,
   input  logic        reset,
   bhcs_stream_if.sink   req,
   bhcs_stream_if.source rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   bhcs_pkg::cfg_type cfg_ff;
   logic [2:0] idx;
   logic ev_valid, space, q_valid, q_take;
   bhcs_pkg::event_type ev_data, q_data;

   assign csr_pready = 1'b1;
   assign idx = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{min_hue: 8'd0, max_hue: 8'd179, min_sat: 8'd0, max_sat: 8'd255,
                     min_val: 8'd0, max_val: 8'd255, pass_fraction: 16'd9830};
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (idx)
            bhcs_pkg::RegMinHue: cfg_ff.min_hue <= csr_pwdata[7:0];
            bhcs_pkg::RegMaxHue: cfg_ff.max_hue <= csr_pwdata[7:0];
            bhcs_pkg::RegMinSat: cfg_ff.min_sat <= csr_pwdata[7:0];
            bhcs_pkg::RegMaxSat: cfg_ff.max_sat <= csr_pwdata[7:0];
            bhcs_pkg::RegMinVal: cfg_ff.min_val <= csr_pwdata[7:0];
            bhcs_pkg::RegMaxVal: cfg_ff.max_val <= csr_pwdata[7:0];
            bhcs_pkg::RegFrac:   cfg_ff.pass_fraction <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         bhcs_pkg::RegMinHue: csr_prdata = {24'd0, cfg_ff.min_hue};
         bhcs_pkg::RegMaxHue: csr_prdata = {24'd0, cfg_ff.max_hue};
         bhcs_pkg::RegMinSat: csr_prdata = {24'd0, cfg_ff.min_sat};
         bhcs_pkg::RegMaxSat: csr_prdata = {24'd0, cfg_ff.max_sat};
         bhcs_pkg::RegMinVal: csr_prdata = {24'd0, cfg_ff.min_val};
         bhcs_pkg::RegMaxVal: csr_prdata = {24'd0, cfg_ff.max_val};
         bhcs_pkg::RegFrac:   csr_prdata = {16'd0, cfg_ff.pass_fraction};
         default:             csr_prdata = 32'd0;
      endcase
   end

   bhcs_front u_front (
      .clock, .reset, .in_valid(req.valid), .in_data(req.data), .in_ready(req.ready),
      .cfg(cfg_ff), .ev_valid, .ev_data, .ev_space(space)
   );

   bhcs_queue u_queue (
      .clock, .reset, .wr_en(ev_valid), .wr_data(ev_data), .space,
      .rd_valid(q_valid), .rd_data(q_data), .rd_en(q_take)
   );

   bhcs_back u_back (
      .clock, .reset, .ev_valid(q_valid), .ev_data(q_data), .ev_take(q_take),
      .pass_fraction(cfg_ff.pass_fraction), .out_valid(rsp.valid), .out_data(rsp.data),
      .out_ready(rsp.ready)
   );
endmodule

### verif/box_hsv_coverage_selector_tb.sv
// Testbench for the box HSV coverage selector: drives pixel words, predicts box results.
// Depends on bhcs_pkg, bhcs_stream_if and the box_hsv_coverage_selector RTL.
module box_hsv_coverage_selector_tb;
   import bhcs_pkg::*;

   logic clock;
   logic reset;
   logic        csr_psel, csr_penable, csr_pwrite;
   logic [4:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   bhcs_stream_if #(.payload_type(req_word_type)) req_ch ();
   bhcs_stream_if #(.payload_type(rsp_word_type)) rsp_ch ();

   box_hsv_coverage_selector dut (
      .clock(clock), .reset(reset), .req(req_ch.sink), .rsp(rsp_ch.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Predictor copy of the registers and the box/winner state.
   cfg_type     lim;
   logic [3:0]  col_ph, row_ph;
   logic [15:0] hit_cnt, smp_cnt;
   logic [5:0]  box_idx;
   logic        best_ok;
   logic [5:0]  best_idx;
   logic [15:0] best_conf;

   req_word_type pixel_queue[$];
   rsp_word_type box_results[$];

   int  errors;
   int  quiet_cycles;
   bit  idle_enable;     // random idling on both sides when set
   bit  hold_sender;     // stalls the driver while pending results drain
   bit  req_fire;        // the offered pixel word was taken at the last rising edge

   task automatic report(input string what, input int got, input int want);
      errors++;
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
   endtask

   // Rounded-to-nearest division, halves up.
   function automatic int unsigned rdiv(input int unsigned n, input int unsigned d);
      return (2 * n + d) / (2 * d);
   endfunction

   // Converts one pixel to HSV and tests it against the inclusive limits.
   function automatic bit hsv_in_limits(input logic [7:0] r, input logic [7:0] g,
                                        input logic [7:0] b);
      int unsigned v, mn, diff, s, h;
      int          delta, offs, n;
      v  = r; mn = r;
      if (g > v) v = g;
      if (b > v) v = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      diff = v - mn;
      s = (v == 0) ? 0 : rdiv(255 * diff, v);
      if (diff == 0) begin
         h = 0;
      end else begin
         if (v == r) begin
            delta = int'(g) - int'(b); offs = 0;
         end else if (v == g) begin
            delta = int'(b) - int'(r); offs = 60;
         end else begin
            delta = int'(r) - int'(g); offs = 120;
         end
         n = offs * int'(diff) + 30 * delta;
         if (n < 0) n += 180 * int'(diff);
         h = rdiv(n, diff);
         if (h >= 180) h -= 180;
      end
      return h >= lim.min_hue && h <= lim.max_hue && s >= lim.min_sat &&
             s <= lim.max_sat && v >= lim.min_val && v <= lim.max_val;
   endfunction

   // Advances the prediction by one accepted pixel word; a box end yields a result.
   task automatic predict_pixel(input req_word_type w);
      rsp_word_type res;
      bit           passes;
      if (col_ph == 0 && row_ph == 0) begin
         if (smp_cnt != 16'hFFFF) smp_cnt++;
         if (hsv_in_limits(w.red, w.green, w.blue) && hit_cnt != 16'hFFFF) hit_cnt++;
      end
      col_ph = (col_ph + 1 >= SampleStep) ? 4'd0 : col_ph + 4'd1;
      if (w.row_end || w.box_end) begin
         col_ph = '0;
         row_ph = (row_ph + 1 >= SampleStep) ? 4'd0 : row_ph + 4'd1;
      end
      if (!w.box_end) return;
      passes = ({32'd0, hit_cnt} << 16) >= 48'(lim.pass_fraction) * 48'(smp_cnt);
      if (passes && (!best_ok || w.box_confidence > best_conf)) begin
         best_ok = 1'b1; best_idx = box_idx; best_conf = w.box_confidence;
      end
      res.box_number = box_idx;
      res.hits = hit_cnt;
      res.samples = smp_cnt;
      res.box_passes = passes;
      res.winner_valid = best_ok;
      res.winner_number = best_idx;
      res.winner_confidence = best_conf;
      res.set_done = w.set_end;
      box_results.push_back(res);
      col_ph = '0; row_ph = '0; hit_cnt = '0; smp_cnt = '0;
      box_idx = box_idx + 6'd1;
      if (w.set_end) begin
         box_idx = '0; best_ok = 1'b0; best_idx = '0; best_conf = '0;
      end
   endtask

   // Driver: offers the next queued pixel word, idling at random.
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_fire) begin
         if (req_fire) void'(pixel_queue.pop_front());
         if (pixel_queue.size() > 0 && !hold_sender
             && !(idle_enable && $urandom_range(99) < 12)) begin
            req_ch.valid <= 1'b1;
            req_ch.data  <= pixel_queue[0];
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Receiver back-pressure.
   always @(negedge clock) begin
      rsp_ch.ready <= !(idle_enable && $urandom_range(99) < 12);
   end

   // Monitor: samples both channels at the rising edge and checks results.
   always @(posedge clock) begin
      req_fire <= req_ch.valid && req_ch.ready;
      if (!reset) begin
         quiet_cycles <= ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                         ? 0 : quiet_cycles + 1;
         if (req_ch.valid && req_ch.ready) begin
            predict_pixel(req_ch.data);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (box_results.size() == 0) begin
               report("unexpected result word", 0, 0);
            end else begin
               rsp_word_type e, g;
               e = box_results.pop_front();
               g = rsp_ch.data;
               if (g.box_number != e.box_number)
                  report("box_number", int'(g.box_number), int'(e.box_number));
               if (g.hits != e.hits) report("hits", int'(g.hits), int'(e.hits));
               if (g.samples != e.samples)
                  report("samples", int'(g.samples), int'(e.samples));
               if (g.box_passes != e.box_passes)
                  report("box_passes", int'(g.box_passes), int'(e.box_passes));
               if (g.winner_valid != e.winner_valid)
                  report("winner_valid", int'(g.winner_valid), int'(e.winner_valid));
               if (g.winner_number != e.winner_number)
                  report("winner_number", int'(g.winner_number), int'(e.winner_number));
               if (g.winner_confidence != e.winner_confidence)
                  report("winner_confidence", int'(g.winner_confidence),
                         int'(e.winner_confidence));
               if (g.set_done != e.set_done)
                  report("set_done", int'(g.set_done), int'(e.set_done));
            end
         end
      end
   end

   // Watchdog on cycles with no accepted word in either direction.
   always @(posedge clock) begin
      if (quiet_cycles > 20000) begin
         $display("box_hsv_coverage_selector_tb: FAIL");
         $finish;
      end
   end

   // Writes one register over APB: setup cycle, then access cycle.
   task automatic csr_write(input logic [2:0] index, input int value);
      @(negedge clock);
      csr_psel <= 1'b1; csr_penable <= 1'b0; csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00}; csr_pwdata <= {16'd0, value[15:0]};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      case (index)
         RegMinHue: lim.min_hue = value[7:0];
         RegMaxHue: lim.max_hue = value[7:0];
         RegMinSat: lim.min_sat = value[7:0];
         RegMaxSat: lim.max_sat = value[7:0];
         RegMinVal: lim.min_val = value[7:0];
         RegMaxVal: lim.max_val = value[7:0];
         RegFrac:   lim.pass_fraction = value[15:0];
         default: ;
      endcase
   endtask

   task automatic write_limits(input int h0, input int h1, input int s0, input int s1,
                               input int v0, input int v1, input int frac);
      csr_write(RegMinHue, h0); csr_write(RegMaxHue, h1);
      csr_write(RegMinSat, s0); csr_write(RegMaxSat, s1);
      csr_write(RegMinVal, v0); csr_write(RegMaxVal, v1);
      csr_write(RegFrac, frac);
   endtask

   // Waits until the queued words are in and every result has come back.
   task automatic drain();
      while (pixel_queue.size() != 0 || req_ch.valid || box_results.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic req_word_type pixel(input int r, input int g, input int b,
                                          input bit re, input bit be, input bit se,
                                          input int conf);
      req_word_type w;
      w.red = 8'(r); w.green = 8'(g); w.blue = 8'(b);
      w.row_end = re; w.box_end = be; w.set_end = se; w.box_confidence = 16'(conf);
      return w;
   endfunction

   // Queues one rectangular box of random pixels; rarely, stray set_end marks.
   task automatic queue_box(input int width, input int height, input bit last,
                            input int conf);
      int x, y;
      for (y = 0; y < height; y++)
         for (x = 0; x < width; x++) begin
            bit be;
            be = (x == width - 1) && (y == height - 1);
            pixel_queue.push_back(pixel($urandom_range(255), $urandom_range(255),
               $urandom_range(255), x == width - 1, be, be ? last : ($urandom_range(49) == 0),
               conf));
         end
   endtask

   initial begin
      int k, nbox;
      reset = 1; errors = 0; quiet_cycles = 0; req_fire = 0;
      idle_enable = 0; hold_sender = 0;
      csr_psel = 0; csr_penable = 0; csr_pwrite = 0; csr_paddr = 0; csr_pwdata = 0;
      req_ch.valid = 0; req_ch.data = '0; rsp_ch.ready = 1;
      lim = '{8'd0, 8'd179, 8'd0, 8'd255, 8'd0, 8'd255, 16'd9830};
      col_ph = '0; row_ph = '0; hit_cnt = '0; smp_cnt = '0;
      box_idx = '0; best_ok = 1'b0; best_idx = '0; best_conf = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Directed: mostly single-pixel boxes covering gray, black, white, each hue sector,
      // the hue that rounds to 180, equal confidences, and an empty-fraction box.
      pixel_queue.push_back(pixel(0, 0, 0, 0, 1, 0, 100));
      pixel_queue.push_back(pixel(255, 255, 255, 1, 1, 0, 100));
      pixel_queue.push_back(pixel(255, 0, 0, 0, 1, 0, 65535));
      pixel_queue.push_back(pixel(0, 255, 0, 0, 1, 0, 65535));
      pixel_queue.push_back(pixel(0, 0, 255, 0, 1, 0, 0));
      pixel_queue.push_back(pixel(255, 0, 1, 0, 1, 0, 7));
      pixel_queue.push_back(pixel(255, 255, 0, 0, 1, 0, 9));
      pixel_queue.push_back(pixel(0, 255, 255, 0, 1, 1, 9));
      pixel_queue.push_back(pixel(128, 127, 1, 0, 0, 1, 0));  // set_end without box_end
      pixel_queue.push_back(pixel(1, 2, 3, 0, 1, 1, 5));
      drain();
      write_limits(179, 0, 255, 0, 255, 0, 0);   // crossed limits, zero fraction
      queue_box(11, 11, 1, 3);
      drain();
      write_limits(0, 179, 0, 255, 0, 255, 65535);
      queue_box(3, 2, 0, 1);
      pixel_queue.push_back(pixel(0, 0, 0, 1, 1, 1, 1));
      drain();

      // Random sets under several limit settings, extremes included.
      idle_enable = 1;
      for (k = 0; k < 6; k++) begin
         case (k)
            0: write_limits(0, 179, 0, 255, 0, 255, 9830);
            1: write_limits(20, 90, 50, 200, 40, 230, 16384);
            2: write_limits($urandom_range(179), $urandom_range(179), $urandom_range(255),
                            $urandom_range(255), $urandom_range(255), $urandom_range(255),
                            $urandom_range(65535));
            3: write_limits(0, 60, 0, 255, 0, 255, 0);
            4: write_limits(100, 179, 30, 255, 10, 255, 40000);
            default: write_limits(0, 179, 0, 128, 0, 128, $urandom_range(32768));
         endcase
         if (k == 2) idle_enable = 0;   // a stretch with no idling
         if (k == 3) idle_enable = 1;
         nbox = $urandom_range(3, 8);
         for (int bi = 0; bi < nbox; bi++)
            queue_box($urandom_range(1, 12), $urandom_range(1, 12), bi == nbox - 1,
                      ($urandom_range(3) == 0) ? 500 : $urandom_range(65535));
         if (k == 4) begin
            // Let traffic start, then pause the sender until every result is back.
            repeat (150) @(posedge clock);
            hold_sender = 1;
            while (box_results.size() != 0 || req_ch.valid) @(posedge clock);
            hold_sender = 0;
         end
         drain();
      end
      // Many boxes in one set so the box counter wraps.
      for (int bi = 0; bi < 70; bi++) queue_box(1, 1, bi == 69, $urandom_range(65535));
      drain();

      if (errors == 0) begin
         $display("box_hsv_coverage_selector_tb: PASS");
      end else begin
         $display("box_hsv_coverage_selector_tb: FAIL");
      end
      $finish;
   end
endmodule

### filelist.f
rtl/core/bhcs_pkg.sv
rtl/core/bhcs_stream_if.sv
rtl/core/bhcs_front.sv
rtl/core/bhcs_queue.sv
rtl/core/bhcs_back.sv
rtl/core/box_hsv_coverage_selector.sv
verif/box_hsv_coverage_selector_tb.sv
